[rtl/text_normalize_pretoken_split_assert.svh]
// Assertion macros shared by the text normaliser and pre-token splitter.
`ifndef TEXT_NORMALIZE_PRETOKEN_SPLIT_ASSERT_SVH
`define TEXT_NORMALIZE_PRETOKEN_SPLIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TNPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TNPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tnps_pkg.sv]
// Types, codes and byte classification functions of the text pre-token splitter.
package tnps_pkg;

    localparam int unsigned MAX_RES = 5;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [2:0] KIND_LETTER = 3'd0;
    localparam logic [2:0] KIND_DIGIT  = 3'd1;
    localparam logic [2:0] KIND_PUNCT  = 3'd2;
    localparam logic [2:0] KIND_CONTR  = 3'd3;
    localparam logic [2:0] KIND_SPACE  = 3'd4;
    localparam logic [2:0] KIND_NONE   = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       chunk_start;
        logic [2:0] chunk_kind;
        logic       out_last;
    } t_res;

    typedef struct packed {
        logic            pending_space;
        logic            seen_non_space;
        logic [2:0][7:0] hold_bytes;
        logic [1:0]      hold_count;
        logic [2:0]      current_kind;
        logic [1:0]      absorb_left;
    } t_state;

    typedef struct packed {
        t_state                 st;
        t_res [MAX_RES-1:0]     res;
        logic [CNT_W-1:0]       n;
    } t_work;

    function automatic t_state state_reset();
        t_state s;
        s.pending_space  = 1'b0;
        s.seen_non_space = 1'b0;
        s.hold_bytes     = '0;
        s.hold_count     = 2'd0;
        s.current_kind   = KIND_NONE;
        s.absorb_left    = 2'd0;
        return s;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || c[7];
    endfunction

    // Number of continuation bytes that a UTF-8 lead byte takes in.
    function automatic logic [1:0] lead_extra(logic [7:0] c);
        logic [1:0] e;
        e = 2'd0;
        if ((c & LEAD2_MASK) == LEAD2_CODE) begin
            e = 2'd1;
        end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
            e = 2'd2;
        end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
            e = 2'd3;
        end
        return e;
    endfunction

    function automatic t_work emit(t_work w, logic [7:0] b, logic start, logic [2:0] kind);
        t_work r;
        r = w;
        if (r.n < CNT_W'(MAX_RES)) begin
            r.res[r.n].out_byte    = b;
            r.res[r.n].has_byte    = 1'b1;
            r.res[r.n].chunk_start = start;
            r.res[r.n].chunk_kind  = kind;
            r.res[r.n].out_last    = 1'b0;
            r.n = r.n + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic t_state hold_push(t_state s, logic [7:0] b);
        t_state r;
        r = s;
        if (r.hold_count < 2'd3) begin
            r.hold_bytes[r.hold_count] = b;
            r.hold_count = r.hold_count + 2'd1;
        end
        return r;
    endfunction

    function automatic t_work apos_punct(t_work w);
        t_work r;
        r = emit(w, CH_APOS, 1'b1, KIND_PUNCT);
        r.st.current_kind = KIND_PUNCT;
        return r;
    endfunction

    // Classifies one normalised byte while nothing is held.
    function automatic t_work classify(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        if (b == CH_SPACE) begin
            r = emit(r, b, 1'b0, KIND_SPACE);
            r.st.current_kind = KIND_NONE;
        end else if ((b == CH_APOS) && (r.st.current_kind != KIND_PUNCT)) begin
            r.st = hold_push(r.st, b);
        end else if (is_letter(b)) begin
            r = emit(r, b, r.st.current_kind != KIND_LETTER, KIND_LETTER);
            r.st.current_kind = KIND_LETTER;
            if (b[7]) begin
                r.st.absorb_left = lead_extra(b);
            end
        end else if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
            r = emit(r, b, 1'b1, KIND_DIGIT);
            r.st.current_kind = KIND_NONE;
        end else begin
            r = emit(r, b, r.st.current_kind != KIND_PUNCT, KIND_PUNCT);
            r.st.current_kind = KIND_PUNCT;
        end
        return r;
    endfunction

    function automatic t_work feed(t_work w, logic [7:0] b);
        t_work      r;
        logic [7:0] x;
        logic       match;
        r = w;
        x = r.st.hold_bytes[1];
        match = (((x == CH_R) || (x == CH_V)) && (b == CH_E)) || ((x == CH_L) && (b == CH_L));
        if (r.st.absorb_left != 2'd0) begin
            if (r.st.absorb_left == 2'd1) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r.st.hold_count) begin
                        r = emit(r, r.st.hold_bytes[i], 1'b0, KIND_LETTER);
                    end
                end
                r = emit(r, b, 1'b0, KIND_LETTER);
                r.st.hold_count  = 2'd0;
                r.st.absorb_left = 2'd0;
            end else begin
                r.st = hold_push(r.st, b);
                r.st.absorb_left = r.st.absorb_left - 2'd1;
            end
        end else if (r.st.hold_count == 2'd1) begin
            if ((b == CH_S) || (b == CH_T) || (b == CH_M) || (b == CH_D)) begin
                r = emit(r, CH_APOS, 1'b1, KIND_CONTR);
                r = emit(r, b, 1'b0, KIND_CONTR);
                r.st.hold_count   = 2'd0;
                r.st.current_kind = KIND_NONE;
            end else if ((b == CH_R) || (b == CH_V) || (b == CH_L)) begin
                r.st = hold_push(r.st, b);
            end else begin
                r.st.hold_count = 2'd0;
                r = apos_punct(r);
                r = classify(r, b);
            end
        end else if (r.st.hold_count >= 2'd2) begin
            r.st.hold_count = 2'd0;
            if (match) begin
                r = emit(r, CH_APOS, 1'b1, KIND_CONTR);
                r = emit(r, x, 1'b0, KIND_CONTR);
                r = emit(r, b, 1'b0, KIND_CONTR);
                r.st.current_kind = KIND_NONE;
            end else begin
                r = apos_punct(r);
                r = classify(r, x);
                r = classify(r, b);
            end
        end else begin
            r = classify(r, b);
        end
        return r;
    endfunction

    // Flushes held bytes at the end of the text; three passes always suffice.
    function automatic t_work finish(t_work w);
        t_work           r;
        logic [2:0][7:0] tmp;
        logic [1:0]      cnt;
        r = w;
        for (int k = 0; k < 3; k++) begin
            if (r.st.absorb_left != 2'd0) begin
                tmp = r.st.hold_bytes;
                cnt = r.st.hold_count;
                r.st.hold_count  = 2'd0;
                r.st.absorb_left = 2'd0;
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < cnt) begin
                        r = feed(r, tmp[i]);
                    end
                end
            end else if (r.st.hold_count == 2'd1) begin
                r.st.hold_count = 2'd0;
                r = apos_punct(r);
            end else if (r.st.hold_count != 2'd0) begin
                r.st.hold_count = 2'd0;
                r = apos_punct(r);
                r = classify(r, r.st.hold_bytes[1]);
            end
        end
        return r;
    endfunction

    // Full processing of one raw byte: normalise, split, and on the last byte close the text.
    function automatic t_work step(t_state s, logic [7:0] raw, logic last);
        t_work      r;
        logic [7:0] c;
        r.st  = s;
        r.res = '0;
        r.n   = '0;
        c     = raw;
        if (is_ws(c)) begin
            if (r.st.seen_non_space) begin
                r.st.pending_space = 1'b1;
            end
        end else begin
            if (r.st.pending_space) begin
                r.st.pending_space = 1'b0;
                r = feed(r, CH_SPACE);
            end
            if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
                c = c + CASE_OFFSET;
            end
            r.st.seen_non_space = 1'b1;
            r = feed(r, c);
        end
        if (last) begin
            r = finish(r);
            if (r.n == '0) begin
                r.res[0].out_byte    = 8'd0;
                r.res[0].has_byte    = 1'b0;
                r.res[0].chunk_start = 1'b0;
                r.res[0].chunk_kind  = KIND_LETTER;
                r.res[0].out_last    = 1'b1;
                r.n = CNT_W'(1);
            end else begin
                r.res[r.n - CNT_W'(1)].out_last = 1'b1;
            end
            r.st = state_reset();
        end
        return r;
    endfunction

endpackage

[rtl/tnps_if.sv]
// Valid/ready channel interfaces for raw text bytes and split results.
interface tnps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface tnps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       chunk_start;
    logic [2:0] chunk_kind;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output chunk_start,
                    output chunk_kind, output out_last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input chunk_start,
                    input chunk_kind, input out_last, output ready);
endinterface

[rtl/text_normalize_pretoken_split.sv]
// Text normaliser and pre-token splitter, top level.
//
// Raw text enters one byte per request on i_text, with text_last on the final
// byte. Each byte is lower-cased, whitespace runs fold to one space, and the
// result stream on o_res carries every normalised byte once with its
// chunk-start mark and kind. One input byte gives between zero and five
// result requests; a text that ends with nothing to emit gives a bare end
// marker with has_byte low.
// A byte is captured in an input register and processed combinationally into a
// five-entry result register, from which its first result is offered.
// A new byte is taken every cycle while each byte yields at most one result
// and o_res is ready; a byte that yields more results occupies the result
// register until its last result is taken, and the input waits until then.
// When o_res stalls, results stay in the result register and the input
// register holds one more byte before i_text.ready falls.
// Reset clears the splitter state and drops all buffered requests; the block
// is ready for a new text in the first cycle after reset.

`include "text_normalize_pretoken_split_assert.svh"

module text_normalize_pretoken_split
    import tnps_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tnps_in_if.sink       i_text,
    tnps_out_if.source    o_res
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    t_state             r_st;
    t_state             n_st;
    t_res [MAX_RES-1:0] r_buf;
    t_res [MAX_RES-1:0] n_buf;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    t_work              w_step;
    logic               w_fire;
    logic               w_pop;

    always_comb begin
        w_step = step(r_st, r_in_byte, r_in_last);
    end

    assign w_pop  = (r_cnt != '0) && o_res.ready;
    assign w_fire = r_in_valid && ((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_res.ready));
    assign i_text.ready = !r_in_valid || w_fire;

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (w_fire) begin
            n_buf = w_step.res;
            n_cnt = w_step.n;
        end else if (w_pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
        n_st = w_fire ? w_step.st : r_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
            r_st       <= state_reset();
        end else begin
            if (i_text.ready) begin
                r_in_valid <= i_text.valid;
            end
            r_cnt <= n_cnt;
            r_st  <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.text_last;
        end
        r_buf <= n_buf;
    end

    assign o_res.valid       = (r_cnt != '0);
    assign o_res.out_byte    = r_buf[0].out_byte;
    assign o_res.has_byte    = r_buf[0].has_byte;
    assign o_res.chunk_start = r_buf[0].chunk_start;
    assign o_res.chunk_kind  = r_buf[0].chunk_kind;
    assign o_res.out_last    = r_buf[0].out_last;

    `TNPS_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, w_fire && r_in_last,
        (r_st.hold_count == 2'd0) && (r_st.absorb_left == 2'd0) && !r_st.pending_space
        && !r_st.seen_non_space, "state not cleared after the final byte")
    `TNPS_ASSERT_NOW(a_last_is_final, i_clk, i_rst_n, r_cnt > CNT_W'(1),
        !r_buf[0].out_last, "end mark on a request that is not the final one")
    `TNPS_ASSERT_NOW(a_hold_bound, i_clk, i_rst_n, 1'b1,
        r_st.hold_count != 2'd3, "more than two bytes held back")
    `TNPS_ASSERT_NOW(a_absorb_in_letter, i_clk, i_rst_n, r_st.absorb_left != 2'd0,
        r_st.current_kind == KIND_LETTER, "continuation absorb outside a letter run")

endmodule

[sim/tb_text_normalize_pretoken_split.sv]
// Self-checking testbench of the text normaliser and pre-token splitter.
module tb_text_normalize_pretoken_split;
    timeunit 1ns;
    timeprecision 1ps;

    import tnps_pkg::*;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } t_text_req;

    localparam int unsigned SEND_QUIET_LO = 150;
    localparam int unsigned SEND_QUIET_HI = 230;
    localparam int unsigned RECV_QUIET_LO = 200;
    localparam int unsigned RECV_QUIET_HI = 300;
    localparam int unsigned HOLDOFF_AT    = 120;
    localparam int unsigned HOLDOFF_LEN   = 100;
    localparam int unsigned DRAIN_AT      = 300;
    localparam int unsigned TARGET_ITEMS  = 410;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tnps_in_if  text_if ();
    tnps_out_if res_if ();

    text_normalize_pretoken_split dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_text_req   text_queue[$];
    t_res        chunks_due[$];
    t_res        step_out[$];
    t_text_req   cur_req;
    int unsigned n_items;
    int unsigned n_sent = 0;
    int unsigned n_got  = 0;
    int unsigned n_err  = 0;
    logic        draining   = 1'b0;
    logic        drain_done = 1'b0;
    logic        holdoff_done = 1'b0;
    int unsigned holdoff_left = 0;

    // Splitter state as seen by the predictor.
    logic       space_pending;
    logic       text_begun;
    logic [7:0] held [3];
    logic [1:0] held_n;
    logic [2:0] open_kind;
    logic [1:0] absorb_n;

    string contractions [13] = '{"'re", "'ve", "'ll", "'s", "'t", "'m", "'d",
                                 "'RE", "'Ll", "'r", "'v", "'l", "'x"};
    string punct_set = "!?.,;:-()\"#@~";

    function automatic void restart_text();
        space_pending = 1'b0;
        text_begun    = 1'b0;
        held          = '{8'd0, 8'd0, 8'd0};
        held_n        = 2'd0;
        open_kind     = KIND_NONE;
        absorb_n      = 2'd0;
    endfunction

    function automatic void put_chunk_byte(logic [7:0] b, logic start, logic [2:0] kind);
        t_res r;
        if (step_out.size() < MAX_RES) begin
            r.out_byte    = b;
            r.has_byte    = 1'b1;
            r.chunk_start = start;
            r.chunk_kind  = kind;
            r.out_last    = 1'b0;
            step_out.insert(step_out.size(), r);
        end
    endfunction

    function automatic void hold_byte(logic [7:0] b);
        if (held_n < 2'd3) begin
            held[held_n] = b;
            held_n = held_n + 2'd1;
        end
    endfunction

    function automatic logic [1:0] utf8_extra(logic [7:0] b);
        casez (b)
            8'b110?_????: return 2'd1;
            8'b1110_????: return 2'd2;
            8'b1111_0???: return 2'd3;
            default:      return 2'd0;
        endcase
    endfunction

    function automatic void apos_as_punct();
        put_chunk_byte(CH_APOS, 1'b1, KIND_PUNCT);
        open_kind = KIND_PUNCT;
    endfunction

    function automatic void classify_norm(logic [7:0] b);
        if (b == CH_SPACE) begin
            put_chunk_byte(b, 1'b0, KIND_SPACE);
            open_kind = KIND_NONE;
        end else if (b == CH_APOS && open_kind != KIND_PUNCT) begin
            hold_byte(b);
        end else if ((b >= CH_LOW_A && b <= CH_LOW_Z) || b[7]) begin
            put_chunk_byte(b, open_kind != KIND_LETTER, KIND_LETTER);
            open_kind = KIND_LETTER;
            if (b[7]) begin
                absorb_n = utf8_extra(b);
            end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            put_chunk_byte(b, 1'b1, KIND_DIGIT);
            open_kind = KIND_NONE;
        end else begin
            put_chunk_byte(b, open_kind != KIND_PUNCT, KIND_PUNCT);
            open_kind = KIND_PUNCT;
        end
    endfunction

    function automatic void split_byte(logic [7:0] b);
        logic [7:0] x;
        if (absorb_n != 2'd0) begin
            if (absorb_n == 2'd1) begin
                for (int i = 0; i < int'(held_n); i++) begin
                    put_chunk_byte(held[i], 1'b0, KIND_LETTER);
                end
                put_chunk_byte(b, 1'b0, KIND_LETTER);
                held_n   = 2'd0;
                absorb_n = 2'd0;
            end else begin
                hold_byte(b);
                absorb_n = absorb_n - 2'd1;
            end
        end else if (held_n == 2'd1) begin
            if (b == CH_S || b == CH_T || b == CH_M || b == CH_D) begin
                put_chunk_byte(CH_APOS, 1'b1, KIND_CONTR);
                put_chunk_byte(b, 1'b0, KIND_CONTR);
                held_n    = 2'd0;
                open_kind = KIND_NONE;
            end else if (b == CH_R || b == CH_V || b == CH_L) begin
                hold_byte(b);
            end else begin
                held_n = 2'd0;
                apos_as_punct();
                classify_norm(b);
            end
        end else if (held_n >= 2'd2) begin
            x      = held[1];
            held_n = 2'd0;
            if (((x == CH_R || x == CH_V) && b == CH_E) || (x == CH_L && b == CH_L)) begin
                put_chunk_byte(CH_APOS, 1'b1, KIND_CONTR);
                put_chunk_byte(x, 1'b0, KIND_CONTR);
                put_chunk_byte(b, 1'b0, KIND_CONTR);
                open_kind = KIND_NONE;
            end else begin
                apos_as_punct();
                classify_norm(x);
                classify_norm(b);
            end
        end else begin
            classify_norm(b);
        end
    endfunction

    function automatic void flush_text();
        logic [7:0] saved [3];
        int         n;
        while (absorb_n != 2'd0 || held_n != 2'd0) begin
            if (absorb_n != 2'd0) begin
                saved    = held;
                n        = int'(held_n);
                held_n   = 2'd0;
                absorb_n = 2'd0;
                for (int i = 0; i < n; i++) begin
                    split_byte(saved[i]);
                end
            end else if (held_n == 2'd1) begin
                held_n = 2'd0;
                apos_as_punct();
            end else begin
                held_n = 2'd0;
                apos_as_punct();
                classify_norm(held[1]);
            end
        end
    endfunction

    function automatic void predict_byte(logic [7:0] raw, logic last);
        logic [7:0] c;
        t_res       r;
        step_out.delete();
        c = raw;
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            if (text_begun) begin
                space_pending = 1'b1;
            end
        end else begin
            if (space_pending) begin
                space_pending = 1'b0;
                split_byte(CH_SPACE);
            end
            if (c >= CH_UP_A && c <= CH_UP_Z) begin
                c = c + CASE_OFFSET;
            end
            text_begun = 1'b1;
            split_byte(c);
        end
        if (last) begin
            flush_text();
            if (step_out.size() == 0) begin
                r            = '0;
                r.chunk_kind = KIND_LETTER;
                r.out_last   = 1'b1;
                step_out.insert(0, r);
            end else begin
                r          = step_out[step_out.size() - 1];
                r.out_last = 1'b1;
                step_out[step_out.size() - 1] = r;
            end
            restart_text();
        end
        foreach (step_out[i]) begin
            chunks_due.insert(chunks_due.size(), step_out[i]);
        end
    endfunction

    function automatic void add_byte(logic [7:0] b, logic last);
        t_text_req q;
        q.text_byte = b;
        q.text_last = last;
        text_queue.insert(text_queue.size(), q);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i], i == s.len() - 1);
        end
    endfunction

    // Mostly well-formed words, contractions, numbers and UTF-8 runs, some pure noise.
    function automatic void add_random_text();
        logic [7:0] txt[$];
        logic [7:0] lead;
        int         n_tok;
        int         len;
        int         cut;
        string      s;
        if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 10);
            repeat (len) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end else begin
            n_tok = $urandom_range(1, 8);
            repeat (n_tok) begin
                case ($urandom_range(0, 8))
                    0, 1: begin
                        repeat ($urandom_range(1, 5)) begin
                            txt.insert(txt.size(), 8'($urandom_range(0, 25))
                                       + ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A));
                        end
                    end
                    2: begin
                        s = contractions[$urandom_range(0, $size(contractions) - 1)];
                        for (int k = 0; k < s.len(); k++) begin
                            txt.insert(txt.size(), s[k]);
                        end
                    end
                    3: begin
                        repeat ($urandom_range(1, 3)) begin
                            txt.insert(txt.size(), CH_ZERO + 8'($urandom_range(0, 9)));
                        end
                    end
                    4: begin
                        repeat ($urandom_range(1, 3)) begin
                            txt.insert(txt.size(),
                                       punct_set[$urandom_range(0, punct_set.len() - 1)]);
                        end
                    end
                    5: begin
                        repeat ($urandom_range(1, 3)) begin
                            case ($urandom_range(0, 3))
                                0: txt.insert(txt.size(), CH_SPACE);
                                1: txt.insert(txt.size(), CH_TAB);
                                2: txt.insert(txt.size(), CH_LF);
                                default: txt.insert(txt.size(), CH_CR);
                            endcase
                        end
                    end
                    6: begin
                        len = $urandom_range(1, 3);
                        case (len)
                            1: lead = LEAD2_CODE | 8'($urandom_range(0, 31));
                            2: lead = LEAD3_CODE | 8'($urandom_range(0, 15));
                            default: lead = LEAD4_CODE | 8'($urandom_range(0, 7));
                        endcase
                        txt.insert(txt.size(), lead);
                        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
                        repeat (len - cut) begin
                            if ($urandom_range(0, 3) == 0) begin
                                txt.insert(txt.size(),
                                           $urandom_range(0, 1) ? CH_SPACE : CH_APOS);
                            end else begin
                                txt.insert(txt.size(), 8'h80 | 8'($urandom_range(0, 63)));
                            end
                        end
                    end
                    7: txt.insert(txt.size(), CH_APOS);
                    default: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
                endcase
            end
        end
        foreach (txt[i]) begin
            add_byte(txt[i], i == txt.size() - 1);
        end
    endfunction

    // Request driver: predicts each accepted byte, then offers the next one.
    always @(posedge i_clk) begin : text_driver
        logic      offer;
        t_text_req nxt;
        if (!i_rst_n) begin
            text_if.valid <= 1'b0;
            restart_text();
        end else begin
            if (text_if.valid && text_if.ready) begin
                predict_byte(cur_req.text_byte, cur_req.text_last);
                n_sent++;
            end
            if (!text_if.valid || text_if.ready) begin
                if (n_sent == DRAIN_AT && !drain_done) begin
                    draining = 1'b1;
                end
                if (draining && chunks_due.size() == 0) begin
                    draining   = 1'b0;
                    drain_done = 1'b1;
                end
                offer = text_queue.size() != 0 && !draining;
                if (!(n_sent >= SEND_QUIET_LO && n_sent < SEND_QUIET_HI)
                    && $urandom_range(0, 99) < 10) begin
                    offer = 1'b0;
                end
                if (offer) begin
                    nxt     = text_queue.pop_front();
                    cur_req = nxt;
                    text_if.valid     <= 1'b1;
                    text_if.text_byte <= nxt.text_byte;
                    text_if.text_last <= nxt.text_last;
                end else begin
                    text_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result ready control, with one long hold-off to back the block up.
    always @(posedge i_clk) begin : res_ready_ctrl
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (!holdoff_done && n_got >= HOLDOFF_AT) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_done = 1'b1;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                res_if.ready <= 1'b0;
            end else if (n_got >= RECV_QUIET_LO && n_got < RECV_QUIET_HI) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge i_clk) begin : res_monitor
        t_res got;
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.out_byte    = res_if.out_byte;
            got.has_byte    = res_if.has_byte;
            got.chunk_start = res_if.chunk_start;
            got.chunk_kind  = res_if.chunk_kind;
            got.out_last    = res_if.out_last;
            n_got <= n_got + 1;
            if (chunks_due.size() == 0) begin
                $display("%0t: unexpected result byte=%h has=%b start=%b kind=%0d last=%b",
                         $realtime, got.out_byte, got.has_byte, got.chunk_start,
                         got.chunk_kind, got.out_last);
                n_err++;
            end else begin
                want = chunks_due.pop_front();
                if (got !== want) begin
                    $display({"%0t: mismatch expected byte=%h has=%b start=%b kind=%0d last=%b",
                              " actual byte=%h has=%b start=%b kind=%0d last=%b"},
                             $realtime, want.out_byte, want.has_byte, want.chunk_start,
                             want.chunk_kind, want.out_last, got.out_byte, got.has_byte,
                             got.chunk_start, got.chunk_kind, got.out_last);
                    n_err++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;

        add_text(" ");
        add_text("\tAZ'LL\r\n");
        add_text("'re'v9");
        add_text("'r");
        add_byte(LEAD3_CODE, 1'b0);
        add_byte(CH_SPACE, 1'b0);
        add_byte(CH_LOW_Z, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(LEAD4_CODE, 1'b0);
        add_byte(CH_LOW_A, 1'b1);
        while (text_queue.size() < TARGET_ITEMS) begin
            add_random_text();
        end
        n_items = text_queue.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_sent == n_items);
        wait (chunks_due.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/tnps_pkg.sv
rtl/tnps_if.sv
rtl/text_normalize_pretoken_split.sv
sim/tb_text_normalize_pretoken_split.sv
